/* sv/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset
`define CHK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* sv/tzpc_pkg.sv */
// Shared constants and types of the two-zone people counter
package tzpc_pkg;

	localparam int WINDOW = 10;
	localparam int DIST_W = 16;
	localparam int COUNT_W = 16;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int PFILL_W = 3;

	// Combined occupancy codes: bit0 left, bit1 right
	localparam logic [1:0] CODE_LEFT  = 2'd1;
	localparam logic [1:0] CODE_RIGHT = 2'd2;
	localparam logic [1:0] CODE_BOTH  = 2'd3;

	localparam logic [PFILL_W-1:0] PATH_START = 3'd1;
	localparam logic [PFILL_W-1:0] PATH_FULL  = 3'd4;
	localparam int PATH_LEN = 3;

	localparam int TDATA_W = 24;

	typedef struct packed {
		logic push;
		logic clear;
	} win_ctrl_t;

endpackage

/* sv/tzpc_window.sv */
// Sliding sample window of one zone with presence detection
module tzpc_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tzpc_pkg::win_ctrl_t         ctrl,
	input  logic [tzpc_pkg::DIST_W-1:0] sample,
	input  logic [tzpc_pkg::DIST_W-1:0] threshold,
	output logic                        occ
);
	import tzpc_pkg::*;

	logic [DIST_W-1:0] taps_q [WINDOW];
	logic [FILL_W-1:0] fill_q;
	logic              hit;

	// min below threshold is the same as any filled entry below threshold;
	// the oldest tap drops out when the window is full
	always_comb begin
		hit = (sample < threshold);
		for (int i = 0; i < WINDOW - 1; i++) begin
			if ((FILL_W'(i) < fill_q) && (taps_q[i] < threshold)) begin
				hit = 1'b1;
			end
		end
	end

	assign occ = hit;

	// newest sample at tap 0
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			taps_q[0] <= sample;
			for (int i = 1; i < WINDOW; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctrl.clear) begin
			fill_q <= '0;
		end else if (ctrl.push && (fill_q < FILL_W'(WINDOW))) begin
			fill_q <= fill_q + 1'b1;
		end
	end

endmodule

/* sv/two_zone_people_counter.sv */
// Two-zone people counter: each input transaction goes through the input register,
// then zone/path logic into the result register. Throughput is one sample per cycle
// while m_tready does not stall; the loop is zone window -> occupancy -> path state.
// Asynchronous active-low reset clears zone, window fills, presence, path, count
// and the threshold; window sample registers are not reset.
module two_zone_people_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tzpc_pkg::DIST_W-1:0]   s_tdata,   // [15:0] distance_mm
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tzpc_pkg::TDATA_W-1:0]  m_tdata,   // [0] zone_occupied, [16:1] person_count,
	                                                 // [17] entered, [18] exited,
	                                                 // [19] path_rejected, [23:20] zero
	output logic                          m_tuser,   // [0] zone
	input  logic                          cfg_we,
	input  logic [tzpc_pkg::DIST_W-1:0]   cfg_wdata  // presence_threshold
);
	import tzpc_pkg::*;

	logic                vld_s1;
	logic [DIST_W-1:0]   dist_s1;
	logic                vld_s2;
	logic                zone_s2, occ_s2, ent_s2, ex_s2, rej_s2;
	logic [COUNT_W-1:0]  count_s2;

	logic [DIST_W-1:0]   thresh_q;
	logic                zone_q, left_q, right_q;
	logic [PFILL_W-1:0]  pfill_q;
	logic [1:0]          path_q [PATH_LEN];
	logic [COUNT_W-1:0]  count_q;

	logic                advance, zone_nx, occ_l, occ_r, occ, ev;
	logic                left_nx, right_nx, both_empty, judge, ent, ex, rej;
	logic [1:0]          code;
	logic [PFILL_W-1:0]  pfill_inc, slot;
	logic [COUNT_W-1:0]  count_nx;
	win_ctrl_t           ctrl_l, ctrl_r;

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign zone_nx  = ~zone_q;

	always_comb begin
		ctrl_l.push  = advance && zone_nx;
		ctrl_r.push  = advance && !zone_nx;
		ctrl_l.clear = advance && judge;
		ctrl_r.clear = advance && judge;
	end

	tzpc_window u_win_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_l),
		.sample    (dist_s1),
		.threshold (thresh_q),
		.occ       (occ_l)
	);

	tzpc_window u_win_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_r),
		.sample    (dist_s1),
		.threshold (thresh_q),
		.occ       (occ_r)
	);

	always_comb begin
		occ = zone_nx ? occ_l : occ_r;
		if (zone_nx) begin
			ev   = (occ != left_q);
			code = {right_q, occ};
		end else begin
			ev   = (occ != right_q);
			code = {occ, left_q};
		end
		left_nx    = (zone_nx && ev) ? occ : left_q;
		right_nx   = (!zone_nx && ev) ? occ : right_q;
		both_empty = !left_nx && !right_nx;
		pfill_inc  = (pfill_q < PATH_FULL) ? pfill_q + 1'b1 : pfill_q;
		slot       = pfill_inc - 3'd2;
		judge      = ev && both_empty && (pfill_inc == PATH_FULL);
		ent = judge && (path_q[0] == CODE_LEFT) && (path_q[1] == CODE_BOTH)
			&& (path_q[2] == CODE_RIGHT);
		ex  = judge && (path_q[0] == CODE_RIGHT) && (path_q[1] == CODE_BOTH)
			&& (path_q[2] == CODE_LEFT);
		rej = judge && !ent && !ex;
		count_nx = count_q;
		if (ent) begin
			count_nx = count_q + 1'b1;
		end else if (ex) begin
			count_nx = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dist_s1 <= s_tdata;
		end
	end

	// zone, presence, path and count state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q  <= 1'b0;
			left_q  <= 1'b0;
			right_q <= 1'b0;
			pfill_q <= PATH_START;
			count_q <= '0;
			for (int i = 0; i < PATH_LEN; i++) begin
				path_q[i] <= '0;
			end
		end else if (advance) begin
			zone_q  <= zone_nx;
			left_q  <= left_nx;
			right_q <= right_nx;
			count_q <= count_nx;
			if (ev) begin
				if (both_empty) begin
					pfill_q <= PATH_START;
				end else begin
					pfill_q        <= pfill_inc;
					path_q[slot[1:0]] <= code;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zone_s2  <= zone_nx;
			occ_s2   <= occ;
			count_s2 <= count_nx;
			ent_s2   <= ent;
			ex_s2    <= ex;
			rej_s2   <= rej;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = zone_s2;
	assign m_tdata  = {4'b0, rej_s2, ex_s2, ent_s2, count_s2, occ_s2};

endmodule

/* sv/tzpc_checker.sv */
// Port-level checks of the people counter and their bind
`include "assert_macros.svh"

module tzpc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [tzpc_pkg::TDATA_W-1:0] m_tdata,
	input logic                         m_tuser
);
	import tzpc_pkg::*;

	logic               out_xfer;
	logic               last_zone_q;
	logic [COUNT_W-1:0] last_cnt_q;
	logic [COUNT_W-1:0] exp_cnt;

	assign out_xfer = m_tvalid && m_tready;
	assign exp_cnt  = last_cnt_q + COUNT_W'(m_tdata[17]) - COUNT_W'(m_tdata[18]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_zone_q <= 1'b0;
			last_cnt_q  <= '0;
		end else if (out_xfer) begin
			last_zone_q <= m_tuser;
			last_cnt_q  <= m_tdata[16:1];
		end
	end

	`CHK_PROP(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`CHK_PROP(a_one_verdict, m_tvalid |-> $onehot0(m_tdata[19:17]), "more than one path verdict")
	`CHK_NEVER(a_zone_alt, out_xfer && (m_tuser == last_zone_q), "zone did not alternate")
	`CHK_NEVER(a_count_step, out_xfer && (m_tdata[16:1] != exp_cnt), "count moved without verdict")

endmodule

bind two_zone_people_counter tzpc_checker u_tzpc_checker (.*);

/* bench/tb_top.sv */
// Self-checking stream testbench for the two-zone people counter
`timescale 1ns / 100ps

module tb_top;
	import tzpc_pkg::*;

	typedef struct {
		logic               zone;
		logic               occupied;
		logic [COUNT_W-1:0] count;
		logic               entered;
		logic               exited;
		logic               rejected;
	} occ_result_t;

	typedef enum {WALK_ENTRY, WALK_EXIT, WALK_SHUFFLE, WALK_NOISE} walk_kind_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [DIST_W-1:0]   s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;
	logic                cfg_we = 1'b0;
	logic [DIST_W-1:0]   cfg_wdata = '0;

	// sample stream waiting for the driver, and per-sample expectations
	logic [DIST_W-1:0] dist_q[$];
	occ_result_t       result_q[$];
	int                errors = 0;
	int                send_idle_pct = 29;
	int                recv_idle_pct = 69;
	int                n_sent = 0;
	logic              left_next = 1'b1;

	// predictor state
	logic [DIST_W-1:0]  threshold = '0;
	logic               zone_q = 1'b0;
	logic [DIST_W-1:0]  win[2][WINDOW];
	int                 win_fill[2] = '{0, 0};
	logic               left_on = 1'b0;
	logic               right_on = 1'b0;
	logic [1:0]         path_codes[PATH_LEN] = '{2'd0, 2'd0, 2'd0};
	logic [PFILL_W-1:0] path_len = PATH_START;
	logic [COUNT_W-1:0] head_count = '0;

	two_zone_people_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic occ_result_t predict_sample(input logic [DIST_W-1:0] dist_mm);
		occ_result_t r;
		int z;
		logic [DIST_W-1:0] low;
		logic occ;
		logic [1:0] code;
		logic ev;
		r = '{default: 0};
		code = 2'd0;
		ev = 1'b0;
		zone_q = ~zone_q;
		z = int'(zone_q);
		if (win_fill[z] < WINDOW) begin
			win[z][win_fill[z]] = dist_mm;
			win_fill[z]++;
		end else begin
			for (int i = 1; i < WINDOW; i++)
				win[z][i-1] = win[z][i];
			win[z][WINDOW-1] = dist_mm;
		end
		low = win[z][0];
		for (int i = 1; i < win_fill[z]; i++)
			if (win[z][i] < low)
				low = win[z][i];
		occ = (low < threshold);
		if (z == 1) begin
			ev = (occ != left_on);
			if (occ)
				code |= CODE_LEFT;
			if (right_on)
				code |= CODE_RIGHT;
			left_on = occ;
		end else begin
			ev = (occ != right_on);
			if (occ)
				code |= CODE_RIGHT;
			if (left_on)
				code |= CODE_LEFT;
			right_on = occ;
		end
		if (ev) begin
			if (path_len < PATH_FULL)
				path_len++;
			if (!left_on && !right_on) begin
				if (path_len == PATH_FULL) begin
					if (path_codes[0] == CODE_LEFT && path_codes[1] == CODE_BOTH &&
					    path_codes[2] == CODE_RIGHT) begin
						head_count++;
						r.entered = 1'b1;
					end else if (path_codes[0] == CODE_RIGHT && path_codes[1] == CODE_BOTH &&
					             path_codes[2] == CODE_LEFT) begin
						head_count--;
						r.exited = 1'b1;
					end else begin
						r.rejected = 1'b1;
					end
					win_fill = '{0, 0};
				end
				path_len = PATH_START;
			end else begin
				// a full path keeps overwriting its last entry
				path_codes[path_len - 2] = code;
			end
		end
		r.zone = zone_q;
		r.occupied = occ;
		r.count = head_count;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < 50)
			$display("tb_top: %s mismatch: got %0d, want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// driver: also predicts each sample at its transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				result_q.push_back(predict_sample(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (dist_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= dist_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		occ_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result, m_tdata", int'(m_tdata), 0);
				end else begin
					want = result_q.pop_front();
					if (m_tuser !== want.zone)
						report_mismatch("zone", int'(m_tuser), int'(want.zone));
					if (m_tdata[0] !== want.occupied)
						report_mismatch("zone_occupied", int'(m_tdata[0]),
						                int'(want.occupied));
					if (m_tdata[16:1] !== want.count)
						report_mismatch("person_count", int'(m_tdata[16:1]),
						                int'(want.count));
					if (m_tdata[17] !== want.entered)
						report_mismatch("entered", int'(m_tdata[17]), int'(want.entered));
					if (m_tdata[18] !== want.exited)
						report_mismatch("exited", int'(m_tdata[18]), int'(want.exited));
					if (m_tdata[19] !== want.rejected)
						report_mismatch("path_rejected", int'(m_tdata[19]),
						                int'(want.rejected));
				end
			end
		end
	end

	function automatic logic [DIST_W-1:0] pick_distance(input logic near);
		if (near && threshold != 0)
			return DIST_W'($urandom_range(threshold - 1, 0));
		else if (near)
			return DIST_W'($urandom_range(65535, 0));
		return DIST_W'($urandom_range(65535, threshold));
	endfunction

	task automatic push_sample(input logic [DIST_W-1:0] dist_mm);
		dist_q.push_back(dist_mm);
		left_next = ~left_next;
		n_sent++;
	endtask

	// hold one occupancy pattern for a number of left/right pairs;
	// ten pairs or more are needed for a zone to read empty again
	task automatic walk_step(input logic want_left, input logic want_right);
		int pairs;
		pairs = ($urandom_range(99, 0) < 85) ? $urandom_range(12, 10) : $urandom_range(9, 1);
		repeat (2 * pairs)
			push_sample(pick_distance(left_next ? want_left : want_right));
	endtask

	task automatic do_walk(input walk_kind_t kind);
		case (kind)
			WALK_ENTRY: begin
				walk_step(1'b1, 1'b0);
				walk_step(1'b1, 1'b1);
				walk_step(1'b0, 1'b1);
				walk_step(1'b0, 1'b0);
			end
			WALK_EXIT: begin
				walk_step(1'b0, 1'b1);
				walk_step(1'b1, 1'b1);
				walk_step(1'b1, 1'b0);
				walk_step(1'b0, 1'b0);
			end
			WALK_SHUFFLE: begin
				repeat ($urandom_range(5, 2))
					walk_step(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
				walk_step(1'b0, 1'b0);
			end
			default: begin
				repeat ($urandom_range(40, 5))
					push_sample($urandom_range(1, 0) ? DIST_W'($urandom_range(65535, 0)) :
					            pick_distance(1'($urandom_range(1, 0))));
			end
		endcase
	endtask

	task automatic run_walks(input int target);
		int stop;
		int roll;
		stop = n_sent + target;
		while (n_sent < stop) begin
			roll = $urandom_range(99, 0);
			if (roll < 40)
				do_walk(WALK_ENTRY);
			else if (roll < 70)
				do_walk(WALK_EXIT);
			else if (roll < 85)
				do_walk(WALK_SHUFFLE);
			else
				do_walk(WALK_NOISE);
		end
	endtask

	// sender stays paused until every expected result is back
	task automatic drain;
		while (dist_q.size() != 0 || s_tvalid || result_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [DIST_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = value;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// threshold still at reset: nothing can be present
		push_sample(16'h0000);
		push_sample(16'hFFFF);
		push_sample(16'h5555);
		push_sample(16'hAAAA);
		push_sample(16'h0001);
		push_sample(16'hFFFE);
		run_walks(100);
		drain();

		write_threshold(16'd1000);
		// equal to the threshold is not present
		push_sample(16'd999);
		push_sample(16'd1000);
		push_sample(16'd1001);
		push_sample(16'd0);
		push_sample(16'hFFFF);
		push_sample(16'd998);
		push_sample(16'd1000);
		push_sample(16'd999);
		walk_step(1'b0, 1'b0);
		walk_step(1'b0, 1'b0);
		// exit first so the count wraps below zero, then back up
		do_walk(WALK_EXIT);
		do_walk(WALK_ENTRY);
		run_walks(250);
		drain();

		send_idle_pct = 69;
		recv_idle_pct = 29;
		write_threshold(16'hFFFF);
		run_walks(300);
		drain();

		write_threshold(16'd1);
		run_walks(250);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_threshold(DIST_W'($urandom_range(65534, 2)));
		run_walks(300);
		drain();

		write_threshold(16'd1000);
		run_walks(250);
		drain();

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
